// ===== hdl/mawf_pkg.sv =====
package mawf_pkg;

  // Default window depth and sample width
  localparam int unsigned WindowDef     = 8;
  localparam int unsigned SampleBitsDef = 24;

  // Zero clamp threshold register
  localparam int unsigned ThrBits  = 23;
  localparam logic [ThrBits-1:0] ThrReset = 23'd500;

  // APB register map
  localparam int unsigned PaddrBits = 3;
  localparam int unsigned PdataBits = 32;
  localparam logic RegIdxThr = 1'b0;

endpackage

// ===== hdl/mawf_ram.sv =====
module mawf_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/moving_average_weight_filter.sv =====
// Boxcar moving average over the last WINDOW valid weight samples. Each beat
// with sample_valid_i high writes the sample into a ring held in a small RAM,
// then the block reads the written entries back one per cycle and adds them
// in a single accumulator, divides the sum by the entry count with a
// restoring divider that produces one quotient bit per cycle, truncates
// toward zero, and forces averages whose magnitude is below the zero clamp
// threshold to zero. A beat with sample_valid_i low repeats the last output
// with updated_o low and changes no state. A valid beat occupies the block
// through the summing pass over the count filled ring entries (at most
// WINDOW) and the divide that follows: the length of the summing pass is set
// by the single RAM read port, that of the divide by the shared subtractor.
// An invalid beat skips both and goes straight to the output state. in_ready_o
// is high only while the block is idle; a result waiting in the output
// register does not block the next input beat.
// Register 0 at byte address 0 is the 23-bit zero clamp threshold (reset 500).
module moving_average_weight_filter
  import mawf_pkg::*;
#(
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   sample_valid_i,
  input  logic [SAMPLE_BITS-1:0] weight_sample_i,
  // Output channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] filtered_weight_o,
  output logic                   updated_o,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PaddrBits-1:0]   paddr,
  input  logic [PdataBits-1:0]   pwdata,
  output logic [PdataBits-1:0]   prdata,
  output logic                   pready
);

  localparam int unsigned AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned SUMW = SAMPLE_BITS + CW;
  localparam int unsigned DCW  = $clog2(SUMW + 1);
  localparam int unsigned CMPW = (SUMW > ThrBits) ? SUMW : ThrBits;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          wpos_q, wpos_d;
  logic                   full_q, full_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          rd_idx_q, rd_idx_d;
  logic                   acc_en_q, acc_en_d;
  logic [DCW-1:0]         div_cnt_q, div_cnt_d;
  logic                   upd_q, upd_d;
  logic [SAMPLE_BITS-1:0] last_q, last_d;
  logic [ThrBits-1:0]     thr_q;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_data_q, out_data_d;
  logic                   out_upd_q, out_upd_d;

  logic [SUMW-1:0]        sum_q, sum_d;
  logic [SUMW-1:0]        dvd_q, dvd_d;
  logic [CW-1:0]          rem_q, rem_d;
  logic                   neg_q, neg_d;

  logic                   in_fire;
  logic                   ram_we;
  logic                   ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   wrap;
  logic [AW-1:0]          wpos_inc;
  logic [CW:0]            trial;
  logic                   trial_ge;
  logic                   slot_free;
  logic [SUMW-1:0]        avg_signed;
  logic                   clamp;
  logic                   cfg_wr;

  // Handshakes
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign ram_we     = in_fire && sample_valid_i;
  assign ram_re     = (state_q == S_SUM) && (rd_idx_q < cnt_q);

  // Ring position advance
  assign wrap     = (wpos_q == AW'(WINDOW - 1));
  assign wpos_inc = wrap ? '0 : AW'(wpos_q + 1'b1);

  // Divider step: shift one dividend bit into the remainder, trial subtract
  assign trial    = {rem_q, dvd_q[SUMW-1]};
  assign trial_ge = (trial >= {1'b0, cnt_q});

  // Signed average and zero clamp
  assign avg_signed = neg_q ? SUMW'(-dvd_q) : dvd_q;
  assign clamp      = (CMPW'(dvd_q) < CMPW'(thr_q));

  mawf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW),
    .ADDR_W(AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wpos_q),
    .wdata_i(weight_sample_i),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    full_d      = full_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    acc_en_d    = 1'b0;
    div_cnt_d   = div_cnt_q;
    upd_d       = upd_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_upd_d   = out_upd_q;
    sum_d       = sum_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    neg_d       = neg_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          upd_d = sample_valid_i;
          if (sample_valid_i) begin
            wpos_d   = wpos_inc;
            full_d   = full_q || wrap;
            cnt_d    = (full_q || wrap) ? CW'(WINDOW) : CW'(wpos_inc);
            rd_idx_d = '0;
            sum_d    = '0;
            state_d  = S_SUM;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SUM: begin
        if (ram_re) begin
          rd_idx_d = CW'(rd_idx_q + 1'b1);
          acc_en_d = 1'b1;
        end
        if (acc_en_q) begin
          sum_d = sum_q + {{CW{ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
        end
        if (!ram_re && !acc_en_q) begin
          neg_d     = sum_q[SUMW-1];
          dvd_d     = sum_q[SUMW-1] ? SUMW'(-sum_q) : sum_q;
          rem_d     = '0;
          div_cnt_d = DCW'(SUMW);
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        rem_d     = trial_ge ? CW'(trial - {1'b0, cnt_q}) : CW'(trial);
        dvd_d     = {dvd_q[SUMW-2:0], trial_ge};
        div_cnt_d = DCW'(div_cnt_q - 1'b1);
        if (div_cnt_q == DCW'(1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_upd_d   = upd_q;
          if (upd_q) begin
            out_data_d = clamp ? '0 : avg_signed[SAMPLE_BITS-1:0];
            last_d     = clamp ? '0 : avg_signed[SAMPLE_BITS-1:0];
          end else begin
            out_data_d = last_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wpos_q      <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      acc_en_q    <= 1'b0;
      div_cnt_q   <= '0;
      upd_q       <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      full_q      <= full_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      acc_en_q    <= acc_en_d;
      div_cnt_q   <= div_cnt_d;
      upd_q       <= upd_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
    out_upd_q  <= out_upd_d;
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_weight_o = out_data_q;
  assign updated_o         = out_upd_q;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegIdxThr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr) begin
      thr_q <= pwdata[ThrBits-1:0];
    end
  end

  assign prdata = (paddr[2] == RegIdxThr) ? PdataBits'(thr_q) : '0;

  // Checks
  a_hold_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !updated_o) |-> (filtered_weight_o == last_q))
    else $error("repeated output differs from last average");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (rd_idx_q <= cnt_q && cnt_q != '0))
    else $error("ring read index beyond filled entries");

  a_rem_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < cnt_q))
    else $error("divider remainder not below divisor");

  a_count_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(WINDOW))
    else $error("entry count exceeds window");

  a_sum_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && state_d == S_DIV) |-> (rd_idx_q == cnt_q))
    else $error("divide started before all entries were summed");

endmodule
